### sv/a8wd_pkg.sv
// Shared constants, command codes and handshake types for the op-8 word delta decoder.
package a8wd_pkg;

  // Frame store geometry.
  localparam int PLANES  = 8;
  localparam int COLUMNS = 32;
  localparam int ROWS    = 256;

  localparam int DEPTH     = PLANES * COLUMNS * ROWS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_CNT_W = $clog2(COLUMNS + 1);
  localparam int ROW_CNT_W = $clog2(ROWS + 1);
  localparam int WORD_W    = 16;

  // Input command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DELTA = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_XOR_MODE = 2'd0;
  localparam logic [1:0] CFG_COLUMNS  = 2'd1;
  localparam logic [1:0] CFG_ROWS     = 2'd2;

  localparam logic [5:0] COLS_RESET = 6'd32;
  localparam logic [8:0] ROWS_RESET = 9'd256;

  // Decode phases of the delta stream.
  localparam logic [2:0] PH_COUNT      = 3'd0;
  localparam logic [2:0] PH_OP         = 3'd1;
  localparam logic [2:0] PH_LITERAL    = 3'd2;
  localparam logic [2:0] PH_FILL_COUNT = 3'd3;
  localparam logic [2:0] PH_FILL_WORD  = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  localparam logic [15:0] RUN_MASK = 16'h7FFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;   // write zero at the clearing address and advance it
    logic capture;    // register the accepted transaction
    logic start;      // start a plane
    logic load_wr;    // load a store word from the input ports
    logic read_issue; // read the store at the input address
    logic exec_step;  // apply a delta word that needs no store access
    logic mem_read;   // read the store word at the decode position
    logic mem_write;  // write the merged word and advance the decoder
    logic out_load;   // place a result in the output register
  } a8wd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic need_mem;
    logic fill_more;
    logic out_busy;
  } a8wd_sts_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [15:0] p, input logic [15:0] c,
                                                   input logic [15:0] r);
    logic [31:0] a;
    a = (32'(p) * 32'(COLUMNS) + 32'(c)) * 32'(ROWS) + 32'(r);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic in_store(input logic [15:0] p, input logic [15:0] c,
                                    input logic [15:0] r);
    return (p < 16'(PLANES)) && (c < 16'(COLUMNS)) && (r < 16'(ROWS));
  endfunction

endpackage

### sv/a8wd_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module a8wd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/a8wd_ctrl.sv
// Controller state machine: sequences clearing, commands, store accesses and results.
module a8wd_ctrl
  import a8wd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  output a8wd_cmd_t  cmd,
  input  a8wd_sts_t  sts
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_cmd)
            CMD_START: cmd.start = 1'b1;
            CMD_LOAD:  cmd.load_wr = 1'b1;
            CMD_READ: begin
              cmd.read_issue = 1'b1;
              state_nxt      = ST_RESULT;
            end
            CMD_DELTA: state_nxt = ST_EXEC;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        if (sts.need_mem) begin
          cmd.mem_read = 1'b1;
          state_nxt    = ST_WRITE;
        end else begin
          cmd.exec_step = 1'b1;
          state_nxt     = ST_RESULT;
        end
      end
      ST_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = sts.fill_more ? ST_EXEC : ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // A store write always follows the read of the same word.
  a_write_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> $past(state_r) == ST_EXEC)
    else $error("write state entered without a preceding read");

  // The clearing pass runs only once after reset.
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_CLEAR |=> state_r != ST_CLEAR)
    else $error("clearing pass re-entered");

  // A loaded result hands control back to the input side.
  a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == ST_IDLE)
    else $error("result load did not return to idle");

endmodule

### sv/a8wd_dp.sv
// Datapath: configuration, decoder state, frame store access and the output register.
module a8wd_dp
  import a8wd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_plane,
  input  logic [4:0]  in_column,
  input  logic [7:0]  in_row,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_plane_finished,
  input  a8wd_cmd_t   cmd,
  output a8wd_sts_t   sts
);

  // Configuration registers.
  logic                 xor_mode_r;
  logic [5:0]           cols_r;
  logic [8:0]           rows_r;

  // Decoder state.
  logic [2:0]           plane_r,  plane_nxt;
  logic [COL_CNT_W-1:0] col_r,    col_nxt;
  logic [ROW_CNT_W-1:0] row_r,    row_nxt;
  logic [15:0]          ops_r,    ops_nxt;
  logic [15:0]          run_r,    run_nxt;
  logic [2:0]           phase_r,  phase_nxt;
  logic                 fin_r,    fin_nxt;

  // Captured transaction.
  logic [15:0]          word_r;
  logic [1:0]           cmd_r;
  logic                 inside_r;

  logic [ADDR_W-1:0]    clr_addr_r;
  logic                 out_valid_r;
  logic [15:0]          out_read_data_r;
  logic                 out_fin_r;

  logic [COL_CNT_W-1:0] col_lim;
  logic [ROW_CNT_W-1:0] row_lim;
  logic                 row_lt_lim;
  logic [ROW_CNT_W-1:0] row_inc;
  logic                 last_col;
  logic [16:0]          skip_sum;
  logic [ROW_CNT_W-1:0] skip_row;
  logic [15:0]          run_dec;
  logic [15:0]          ops_dec;
  logic                 dec_inside;
  logic [ADDR_W-1:0]    dec_addr;
  logic                 in_inside;
  logic [ADDR_W-1:0]    in_addr;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [15:0]          ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [15:0]          ram_q;

  // Effective limits after clamping the configuration values.
  always_comb begin
    if (cols_r == '0) begin
      col_lim = COL_CNT_W'(1);
    end else if (16'(cols_r) > 16'(COLUMNS)) begin
      col_lim = COL_CNT_W'(COLUMNS);
    end else begin
      col_lim = COL_CNT_W'(cols_r);
    end
    if (16'(rows_r) > 16'(ROWS)) begin
      row_lim = ROW_CNT_W'(ROWS);
    end else begin
      row_lim = ROW_CNT_W'(rows_r);
    end
  end

  assign row_lt_lim = (row_r < row_lim);
  assign row_inc    = row_r + ROW_CNT_W'(1);
  assign last_col   = (16'(col_r) + 16'd1) >= 16'(col_lim);
  assign skip_sum   = 17'(row_r) + 17'(word_r);
  assign skip_row   = (skip_sum > 17'(row_lim)) ? row_lim : ROW_CNT_W'(skip_sum);
  assign run_dec    = run_r - 16'd1;
  assign ops_dec    = ops_r - 16'd1;
  assign dec_inside = in_store(16'(plane_r), 16'(col_r), 16'(row_r));
  assign dec_addr   = store_addr(16'(plane_r), 16'(col_r), 16'(row_r));
  assign in_inside  = in_store(16'(in_plane), 16'(in_column), 16'(in_row));
  assign in_addr    = store_addr(16'(in_plane), 16'(in_column), 16'(in_row));

  assign sts.clear_last = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign sts.need_mem   = ((phase_r == PH_LITERAL) || (phase_r == PH_FILL_WORD)) && row_lt_lim;
  assign sts.fill_more  = (phase_r == PH_FILL_WORD) && (run_dec != '0) && (row_inc < row_lim);
  assign sts.out_busy   = out_valid_r && !out_ready;

  // Decoder next state.
  always_comb begin
    logic        end_op;
    logic [15:0] end_ops;
    logic        end_col;
    end_op    = 1'b0;
    end_ops   = ops_r;
    end_col   = 1'b0;
    plane_nxt = plane_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ops_nxt   = ops_r;
    run_nxt   = run_r;
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    if (cmd.start) begin
      plane_nxt = in_plane;
      col_nxt   = '0;
      row_nxt   = '0;
      ops_nxt   = '0;
      run_nxt   = '0;
      fin_nxt   = 1'b0;
      phase_nxt = PH_COUNT;
    end else if (cmd.exec_step) begin
      unique case (phase_r)
        PH_COUNT: begin
          ops_nxt = word_r;
          row_nxt = '0;
          if (word_r == '0) begin
            end_col = 1'b1;
          end else begin
            phase_nxt = PH_OP;
          end
        end
        PH_OP: begin
          ops_nxt = ops_dec;
          end_ops = ops_dec;
          if (word_r[15]) begin
            run_nxt = word_r & RUN_MASK;
            if ((word_r & RUN_MASK) == '0) begin
              end_op = 1'b1;
            end else begin
              phase_nxt = PH_LITERAL;
            end
          end else if (word_r == '0) begin
            phase_nxt = PH_FILL_COUNT;
          end else begin
            row_nxt = skip_row;
            end_op  = 1'b1;
          end
        end
        PH_LITERAL: begin
          // The row is at or past the limit: the word is dropped.
          row_nxt = row_lim;
          run_nxt = run_dec;
          end_op  = (run_dec == '0);
        end
        PH_FILL_COUNT: begin
          run_nxt = word_r;
          if (word_r == '0) begin
            end_op = 1'b1;
          end else begin
            phase_nxt = PH_FILL_WORD;
          end
        end
        PH_FILL_WORD: begin
          if (row_r > row_lim) begin
            row_nxt = row_lim;
          end
          run_nxt = '0;
          end_op  = 1'b1;
        end
        default: phase_nxt = phase_r;
      endcase
    end else if (cmd.mem_write) begin
      row_nxt = row_inc;
      run_nxt = run_dec;
      if (phase_r == PH_LITERAL) begin
        end_op = (run_dec == '0);
      end else if ((run_dec == '0) || (row_inc >= row_lim)) begin
        run_nxt = '0;
        end_op  = 1'b1;
      end
    end

    if (end_op) begin
      if (end_ops == '0) begin
        end_col = 1'b1;
      end else begin
        phase_nxt = PH_OP;
      end
    end
    if (end_col) begin
      col_nxt = col_r + COL_CNT_W'(1);
      row_nxt = '0;
      if (last_col) begin
        fin_nxt   = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_COUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_mode_r  <= 1'b0;
      cols_r      <= COLS_RESET;
      rows_r      <= ROWS_RESET;
      plane_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      ops_r       <= '0;
      run_r       <= '0;
      phase_r     <= PH_COUNT;
      fin_r       <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_XOR_MODE: xor_mode_r <= cfg_data[0];
          CFG_COLUMNS:  cols_r     <= cfg_data[5:0];
          CFG_ROWS:     rows_r     <= cfg_data;
          default:      ;
        endcase
      end
      plane_r <= plane_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ops_r   <= ops_nxt;
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r   <= in_data_word;
      cmd_r    <= in_cmd;
      inside_r <= in_inside;
    end
    if (cmd.out_load) begin
      out_read_data_r <= ((cmd_r == CMD_READ) && inside_r) ? ram_q : 16'd0;
      out_fin_r       <= fin_r;
    end
  end

  // Store port selection: clearing, direct load or decoder read-modify-write.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.load_wr) begin
      ram_we    = in_inside;
      ram_waddr = in_addr;
      ram_wdata = in_data_word;
    end else if (cmd.mem_write) begin
      ram_we    = dec_inside;
      ram_waddr = dec_addr;
      ram_wdata = (ram_q & {WORD_W{xor_mode_r}}) ^ word_r;
    end
  end

  assign ram_re    = cmd.read_issue || cmd.mem_read;
  assign ram_raddr = cmd.read_issue ? in_addr : dec_addr;

  a8wd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_plane_finished = out_fin_r;

  // The finished flag and the done phase always move together.
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r == (phase_r == PH_DONE))
    else $error("finished flag and decode phase disagree");

  // A run phase is never left with an empty run count.
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LITERAL || phase_r == PH_FILL_WORD) |-> run_r != '0)
    else $error("run phase with zero run count");

  // A decoder write merges the word read in the cycle before.
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_write |-> $past(cmd.mem_read))
    else $error("decoder write without preceding read");

endmodule

### sv/anim8_word_delta_decoder.sv
// Top level of the op-8 word delta decoder with its planar frame store.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_cmd, in_plane, in_column, in_row, in_data_word
//   out_     output     out_valid / out_ready  out_read_data, out_plane_finished
//   cfg_     input      cfg_write_en           cfg_index, cfg_data
//
// Steps: a start or load transaction is taken in idle alone and a read passes through the result
//   state; a delta control word, or a literal or fill word whose row is at the row limit, passes
//   exec and result, a written literal word exec, write and result, and a fill word exec and write
//   per row written. Each decoder write is a read-modify-write through the RAM's single read port.
// Reset: rst_n is synchronous; after it the controller clears the frame store one word per
//   cycle, all 65536 words for the default geometry, and in_ready stays low meanwhile.
//   Configuration writes are taken during the clearing pass.
// Stalls: a result waits in the output register; the next transaction is taken while it waits,
//   and only a second result holds the controller until the first one is taken.
//
// Start, delta, read and load commands share the input channel. Delta and read commands each
// give one result transaction; start and load give none. The decode position (plane, column,
// row), the op and run counters and the decode phase live in the datapath, next to the frame
// store, while the controller decides which step runs in each cycle.
module anim8_word_delta_decoder
  import a8wd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_plane,
  input  logic [4:0]  in_column,
  input  logic [7:0]  in_row,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_plane_finished
);

  a8wd_cmd_t ctl_cmd;
  a8wd_sts_t dp_sts;

  // The controller accepts one transaction at a time and steps it through the datapath.
  a8wd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_cmd),
    .in_ready(in_ready),
    .cmd     (ctl_cmd),
    .sts     (dp_sts)
  );

  // The datapath holds the configuration, the decoder state, the store and the result register.
  a8wd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cmd            (in_cmd),
    .in_plane          (in_plane),
    .in_column         (in_column),
    .in_row            (in_row),
    .in_data_word      (in_data_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_plane_finished(out_plane_finished),
    .cmd               (ctl_cmd),
    .sts               (dp_sts)
  );

endmodule
